/* hw/rtl/ppmfd_pkg.sv */
// Shared constants, codes and types for the PPM frame decoder.
package ppmfd_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS + 1);
    localparam int CH_LIMIT_W  = 5;
    localparam int LIMIT_CMP_W = (SLOT_IDX_W > CH_LIMIT_W) ? SLOT_IDX_W : CH_LIMIT_W;
    localparam int TIME_W      = 32;
    localparam int PULSE_W     = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PULSE_W-1:0] SYNC_LOW  = 16'd3000;
    localparam logic [PULSE_W-1:0] SYNC_HIGH = 16'd12000;
    localparam logic [PULSE_W-1:0] PULSE_SAT = 16'hFFFF;

    localparam logic [CH_LIMIT_W-1:0] CHANNEL_LIMIT_RESET = 5'd8;
    localparam logic [PULSE_W-1:0]    MIN_PULSE_RESET     = 16'd1000;
    localparam logic [PULSE_W-1:0]    MAX_PULSE_RESET     = 16'd2000;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PULSE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PULSE     = 2'd2;

    // Item kinds.
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [CH_LIMIT_W-1:0] channel_limit;
        logic [PULSE_W-1:0]    min_pulse_us;
        logic [PULSE_W-1:0]    max_pulse_us;
    } cfg_t;

    typedef struct packed {
        logic                  kind;
        logic [TIME_W-1:0]     edge_time_us;
        logic [CH_LIMIT_W-1:0] read_channel;
    } item_t;

    typedef struct packed {
        logic                  sync_seen;
        logic                  slot_written;
        logic [SLOT_OUT_W-1:0] slot_number;
        logic [PULSE_W-1:0]    pulse_value;
        logic                  frame_available;
    } result_t;

endpackage

/* hw/rtl/ppm_frame_decoder_top.sv */
// Top level of the PPM frame decoder: input register, decoder and result register.
//
// Usage:
//   Items enter on the item channel (item_valid, item_stall; fields kind,
//   edge_time_us, read_channel). A transfer happens at a rising edge with
//   item_valid high and item_stall low. Each item gives exactly one result on
//   the result channel (result_valid, result_stall; fields sync_seen,
//   slot_written, slot_number, pulse_value, frame_available).
//   A transferred item is held in the input register, decoded combinationally
//   and its result loaded into the result register when that register is empty
//   or not stalled. Throughput is one item per cycle when not stalled, set by the
//   single decode stage between the two registers. When the receiver stalls, the
//   result register holds its value and the input register keeps one more item,
//   after which item_stall rises. Registers are written on the cfg channel
//   (cfg_valid, cfg_ready always high, cfg_index, cfg_data); the user must write
//   them only while no item is in flight, which the block does not enforce. Reset
//   clears the timestamp, stored channels and available flag, loads the register
//   defaults and, at the default limit, arms no slot until the first sync.
module ppm_frame_decoder_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppmfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               kind,
    input  logic [ppmfd_pkg::TIME_W-1:0]       edge_time_us,
    input  logic [ppmfd_pkg::CH_LIMIT_W-1:0]   read_channel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               sync_seen,
    output logic                               slot_written,
    output logic [ppmfd_pkg::SLOT_OUT_W-1:0]   slot_number,
    output logic [ppmfd_pkg::PULSE_W-1:0]      pulse_value,
    output logic                               frame_available
);
    import ppmfd_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    logic    item_take;

    ppmfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppmfd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result_next)
    );

    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.kind         <= kind;
            item_reg.edge_time_us <= edge_time_us;
            item_reg.read_channel <= read_channel;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid    = result_valid_reg;
    assign sync_seen       = result_reg.sync_seen;
    assign slot_written    = result_reg.slot_written;
    assign slot_number     = result_reg.slot_number;
    assign pulse_value     = result_reg.pulse_value;
    assign frame_available = result_reg.frame_available;

endmodule

/* hw/rtl/ppmfd_cfg.sv */
// Configuration register file for the PPM frame decoder.
module ppmfd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppmfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppmfd_pkg::cfg_t                    cfg
);
    import ppmfd_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_limit <= CHANNEL_LIMIT_RESET;
            cfg_reg.min_pulse_us  <= MIN_PULSE_RESET;
            cfg_reg.max_pulse_us  <= MAX_PULSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CHANNEL_LIMIT: cfg_reg.channel_limit <= cfg_data[CH_LIMIT_W-1:0];
                REG_MIN_PULSE:     cfg_reg.min_pulse_us  <= cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE:     cfg_reg.max_pulse_us  <= cfg_data[PULSE_W-1:0];
                default:           ;
            endcase
        end
    end

endmodule

/* hw/rtl/ppmfd_decode.sv */
// Interval measurement, sync detection, slot store and channel readback.
module ppmfd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  ppmfd_pkg::cfg_t    cfg,
    input  ppmfd_pkg::item_t   item,
    input  logic               advance,
    output ppmfd_pkg::result_t result
);
    import ppmfd_pkg::*;

    logic [TIME_W-1:0]     prev_time_reg;
    logic [SLOT_IDX_W-1:0] slot_index_reg;
    logic                  avail_reg;
    logic [PULSE_W-1:0]    channel_reg [MAX_SLOTS];

    logic [TIME_W-1:0]      diff;
    logic [PULSE_W-1:0]     interval;
    logic                   is_sync;
    logic                   is_long;
    logic [LIMIT_CMP_W-1:0] limit_wide;
    logic [LIMIT_CMP_W-1:0] eff_limit;
    logic                   slot_armed;
    logic [PULSE_W-1:0]     clamped;
    logic                   read_in_range;
    logic [CH_LIMIT_W-1:0]  read_offset;
    logic [SLOT_W-1:0]      write_slot;
    logic                   is_edge;
    logic                   do_write;
    logic                   avail_next;

    assign is_edge = (item.kind == KIND_EDGE);

    // The wrap of the timestamp counter is absorbed by the modular subtract.
    assign diff     = item.edge_time_us - prev_time_reg;
    assign interval = (|diff[TIME_W-1:PULSE_W]) ? PULSE_SAT : diff[PULSE_W-1:0];
    assign is_sync  = (interval > SYNC_LOW) && (interval < SYNC_HIGH);
    assign is_long  = (interval > SYNC_HIGH);

    assign limit_wide = LIMIT_CMP_W'(cfg.channel_limit);
    assign eff_limit  = (limit_wide > LIMIT_CMP_W'(MAX_SLOTS)) ?
                        LIMIT_CMP_W'(MAX_SLOTS) : limit_wide;
    assign slot_armed = (LIMIT_CMP_W'(slot_index_reg) < eff_limit);

    // When the bounds are crossed, the lower bound wins below it and the upper bound otherwise.
    assign clamped = (interval < cfg.min_pulse_us) ? cfg.min_pulse_us :
                     (interval > cfg.max_pulse_us) ? cfg.max_pulse_us : interval;

    assign write_slot = slot_index_reg[SLOT_W-1:0];
    assign do_write   = is_edge && !is_sync && slot_armed;

    assign read_in_range = (item.read_channel != '0) &&
                           (LIMIT_CMP_W'(item.read_channel) <= LIMIT_CMP_W'(MAX_SLOTS));
    assign read_offset   = item.read_channel - CH_LIMIT_W'(1);

    always_comb
    begin
        avail_next = avail_reg;
        if (is_edge)
        begin
            if (is_sync)
            begin
                avail_next = 1'b1;
            end
            else if (is_long)
            begin
                avail_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result                 = '0;
        result.frame_available = avail_next;
        if (!is_edge)
        begin
            if (read_in_range)
            begin
                result.pulse_value = channel_reg[read_offset[SLOT_W-1:0]];
            end
        end
        else if (is_sync)
        begin
            result.sync_seen = 1'b1;
        end
        else if (do_write)
        begin
            result.slot_written = 1'b1;
            result.slot_number  = SLOT_OUT_W'(slot_index_reg);
            result.pulse_value  = clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg  <= '0;
            slot_index_reg <= SLOT_IDX_W'(CHANNEL_LIMIT_RESET);
            avail_reg      <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                channel_reg[i] <= '0;
            end
        end
        else if (advance && is_edge)
        begin
            prev_time_reg <= item.edge_time_us;
            avail_reg     <= avail_next;
            if (is_sync)
            begin
                slot_index_reg <= '0;
            end
            else if (do_write)
            begin
                channel_reg[write_slot] <= clamped;
                slot_index_reg          <= slot_index_reg + SLOT_IDX_W'(1);
            end
        end
    end

    a_sync_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_edge && is_sync |=> (slot_index_reg == '0) && avail_reg)
        else $error("sync edge did not clear the slot index and set available");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        advance && do_write |=> slot_index_reg == $past(slot_index_reg) + SLOT_IDX_W'(1))
        else $error("slot index did not step after a store");

    a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_edge |=> $stable(prev_time_reg) && $stable(slot_index_reg)
                                && $stable(avail_reg))
        else $error("read item changed decoder state");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        LIMIT_CMP_W'(slot_index_reg) <= LIMIT_CMP_W'(MAX_SLOTS))
        else $error("slot index ran past the slot count");

endmodule
